FILE: rtl/clp_pkg.sv
`default_nettype none

package clp_pkg;

    typedef enum logic [2:0] {
        LM_BETWEEN = 3'd0,
        LM_COMMENT = 3'd1,
        LM_IDENT   = 3'd2,
        LM_NUMBER  = 3'd3,
        LM_STR_NEW = 3'd4,
        LM_STR_IN  = 3'd5
    } lex_mode_t;

    typedef enum logic [2:0] {
        GS_LINE  = 3'd0,
        GS_NAME  = 3'd1,
        GS_EQ    = 3'd2,
        GS_VALUE = 3'd3,
        GS_COMMA = 3'd4,
        GS_ATTR  = 3'd5
    } gram_state_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_CHAR   = 3'd1,
        ERR_STRING = 3'd2,
        ERR_TOKEN  = 3'd3,
        ERR_RECORD = 3'd4
    } err_code_t;

    typedef enum logic [2:0] {
        ROLE_SKIP  = 3'd0,
        ROLE_NAME  = 3'd1,
        ROLE_VALUE = 3'd2,
        ROLE_ATTR  = 3'd3,
        ROLE_END   = 3'd4
    } role_t;

    typedef enum logic [3:0] {
        CC_SPACE   = 4'd0,
        CC_SEMI    = 4'd1,
        CC_NEWLINE = 4'd2,
        CC_EQ      = 4'd3,
        CC_COMMA   = 4'd4,
        CC_QUOTE   = 4'd5,
        CC_IDENT   = 4'd6,
        CC_DIGIT   = 4'd7,
        CC_BAD     = 4'd8
    } char_class_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5a;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        char_class_t cls;
    } clp_word_t;

endpackage

`default_nettype wire

FILE: rtl/config_line_lexer_parser.sv
// Configuration line lexer and parser.
// Input channel (in_valid/in_ready) takes one text byte per word with a
// last_byte flag; output channel (out_valid/out_ready) gives one result word
// per byte: echoed byte, content flag, role, token start, default-value flag
// on record end, sticky error code and done flag on the last byte.
// The front classifies each byte and writes it into a small queue of
// QUEUE_DEPTH words; the back runs the lexer and grammar state machine on
// the queue head and holds the result in an output register.
// An accepted byte goes into the queue; the back pops the queue head and
// registers its result in the output register. Throughput: one byte per
// cycle without stalls, set by the back's single state update per cycle.
// When the receiver stalls the output register holds, the queue fills and
// in_ready drops once QUEUE_DEPTH words are waiting.
// Reset empties the queue and output register and returns the parser to
// line start with no error; a last byte does the same after its result.
`default_nettype none

module config_line_lexer_parser
    import clp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      char_out,
    output logic            char_valid,
    output logic [2:0]      role,
    output logic            token_start,
    output logic            default_value,
    output logic [2:0]      error_code,
    output logic            done_res
);

    clp_word_t in_word;
    clp_word_t head_word;
    logic      q_full, q_not_empty, q_pop, q_push;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    clp_front u_front (
        .byte_in   (byte_in),
        .last_byte (last_byte),
        .word      (in_word)
    );

    clp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (in_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (head_word)
    );

    clp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_not_empty),
        .head_word     (head_word),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_out      (char_out),
        .char_valid    (char_valid),
        .role          (role),
        .token_start   (token_start),
        .default_value (default_value),
        .error_code    (error_code),
        .done_res      (done_res)
    );

endmodule

`default_nettype wire

FILE: rtl/clp_front.sv
`default_nettype none

module clp_front
    import clp_pkg::*;
(
    input  wire logic [7:0] byte_in,
    input  wire logic       last_byte,
    output clp_word_t       word
);

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t k;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            k = CC_SPACE;
        else if (c == CH_SEMI)
            k = CC_SEMI;
        else if (c == CH_LF)
            k = CC_NEWLINE;
        else if (c == CH_EQ)
            k = CC_EQ;
        else if (c == CH_COMMA)
            k = CC_COMMA;
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
            k = CC_QUOTE;
        else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
                 c == CH_BSLASH || c == CH_DASH || c == CH_USCORE ||
                 c == CH_AT || c == CH_DOT)
            k = CC_IDENT;
        else if (c >= CH_0 && c <= CH_9)
            k = CC_DIGIT;
        else
            k = CC_BAD;
        return k;
    endfunction

    always_comb
    begin
        word.data = byte_in;
        word.last = last_byte;
        word.cls  = classify(byte_in);
    end

endmodule

`default_nettype wire

FILE: rtl/clp_queue.sv
`default_nettype none

module clp_queue
    import clp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  clp_word_t      push_word,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output clp_word_t      head_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    clp_word_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

`default_nettype wire

FILE: rtl/clp_back.sv
`default_nettype none

module clp_back
    import clp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  clp_word_t       head_word,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      char_out,
    output logic            char_valid,
    output logic [2:0]      role,
    output logic            token_start,
    output logic            default_value,
    output logic [2:0]      error_code,
    output logic            done_res
);

    lex_mode_t   lex_reg, lex_next;
    logic [7:0]  quote_reg, quote_next;
    gram_state_t gram_reg, gram_next;
    logic        vseen_reg, vseen_next;
    err_code_t   err_reg, err_next;

    logic        out_valid_reg;
    logic [7:0]  char_reg;
    logic        cvalid_reg;
    role_t       role_reg;
    logic        start_reg;
    logic        dflt_reg;
    err_code_t   ecode_reg;
    logic        done_reg;

    logic        t_valid, t_start, t_dflt, fresh, open_ok;
    role_t       t_role;
    err_code_t   t_err;
    gram_state_t open_gram;
    logic [7:0]  c;
    char_class_t cls;

    function automatic role_t role_of(input gram_state_t g);
        role_t r;
        unique case (g)
            GS_NAME:  r = ROLE_NAME;
            GS_VALUE: r = ROLE_VALUE;
            GS_ATTR:  r = ROLE_ATTR;
            default:  r = ROLE_SKIP;
        endcase
        return r;
    endfunction

    assign pop = head_valid && (!out_valid_reg || out_ready);
    assign c   = head_word.data;
    assign cls = head_word.cls;

    // grammar move for a token opening at this byte
    always_comb
    begin
        open_ok   = 1'b1;
        open_gram = gram_reg;
        unique case (gram_reg)
            GS_LINE:
            begin
                open_gram = GS_NAME;
                open_ok   = (cls != CC_DIGIT);
            end
            GS_EQ:    open_gram = GS_VALUE;
            GS_COMMA: open_gram = GS_ATTR;
            default:  open_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        lex_next   = lex_reg;
        quote_next = quote_reg;
        gram_next  = gram_reg;
        vseen_next = vseen_reg;
        err_next   = err_reg;
        t_valid    = 1'b0;
        t_role     = ROLE_SKIP;
        t_start    = 1'b0;
        t_dflt     = 1'b0;
        t_err      = ERR_NONE;
        fresh      = 1'b0;

        if (err_reg == ERR_NONE)
        begin
            if (lex_reg == LM_STR_NEW || lex_reg == LM_STR_IN)
            begin
                t_role = role_of(gram_reg);
                if (c == quote_reg)
                    lex_next = LM_BETWEEN;
                else if (lex_reg == LM_STR_NEW && gram_reg == GS_NAME && cls == CC_DIGIT)
                    t_err = ERR_TOKEN;
                else
                begin
                    lex_next = LM_STR_IN;
                    t_valid  = 1'b1;
                end
            end
            else
            begin
                unique case (lex_reg)
                    LM_COMMENT: fresh = (cls == CC_NEWLINE);
                    LM_IDENT:
                    begin
                        if (cls == CC_IDENT || cls == CC_DIGIT)
                        begin
                            t_role  = role_of(gram_reg);
                            t_valid = 1'b1;
                        end
                        else
                            fresh = 1'b1;
                    end
                    LM_NUMBER:
                    begin
                        if (cls == CC_DIGIT)
                        begin
                            t_role  = role_of(gram_reg);
                            t_valid = 1'b1;
                        end
                        else
                            fresh = 1'b1;
                    end
                    default: fresh = 1'b1;
                endcase

                if (fresh)
                begin
                    lex_next = LM_BETWEEN;
                    case (cls)
                        CC_SPACE: ;
                        CC_SEMI:  lex_next = LM_COMMENT;
                        CC_NEWLINE:
                        begin
                            if (gram_reg == GS_EQ || gram_reg == GS_COMMA)
                                t_err = ERR_TOKEN;
                            else if (gram_reg != GS_LINE)
                            begin
                                t_role     = ROLE_END;
                                t_dflt     = !vseen_reg;
                                gram_next  = GS_LINE;
                                vseen_next = 1'b0;
                            end
                        end
                        CC_EQ:
                        begin
                            if (gram_reg != GS_NAME)
                                t_err = ERR_TOKEN;
                            else
                            begin
                                gram_next  = GS_EQ;
                                vseen_next = 1'b1;
                            end
                        end
                        CC_COMMA:
                        begin
                            if (gram_reg == GS_NAME || gram_reg == GS_VALUE ||
                                gram_reg == GS_ATTR)
                                gram_next = GS_COMMA;
                            else
                                t_err = ERR_TOKEN;
                        end
                        CC_QUOTE, CC_IDENT, CC_DIGIT:
                        begin
                            if (!open_ok)
                                t_err = ERR_TOKEN;
                            else
                            begin
                                gram_next = open_gram;
                                t_role    = role_of(open_gram);
                                t_start   = 1'b1;
                                if (cls == CC_QUOTE)
                                begin
                                    quote_next = c;
                                    lex_next   = LM_STR_NEW;
                                end
                                else
                                begin
                                    lex_next = (cls == CC_IDENT) ? LM_IDENT : LM_NUMBER;
                                    t_valid  = 1'b1;
                                end
                            end
                        end
                        default: t_err = ERR_CHAR;
                    endcase
                end
            end

            if (t_err != ERR_NONE)
            begin
                err_next = t_err;
                t_valid  = 1'b0;
                t_role   = ROLE_SKIP;
                t_start  = 1'b0;
                t_dflt   = 1'b0;
            end
        end

        if (head_word.last && err_next == ERR_NONE)
        begin
            if (lex_next == LM_STR_NEW || lex_next == LM_STR_IN)
                err_next = ERR_STRING;
            else if (gram_next != GS_LINE)
                err_next = ERR_RECORD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_reg       <= LM_BETWEEN;
            quote_reg     <= '0;
            gram_reg      <= GS_LINE;
            vseen_reg     <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head_word.last)
                begin
                    lex_reg   <= LM_BETWEEN;
                    quote_reg <= '0;
                    gram_reg  <= GS_LINE;
                    vseen_reg <= 1'b0;
                    err_reg   <= ERR_NONE;
                end
                else
                begin
                    lex_reg   <= lex_next;
                    quote_reg <= quote_next;
                    gram_reg  <= gram_next;
                    vseen_reg <= vseen_next;
                    err_reg   <= err_next;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            char_reg   <= c;
            cvalid_reg <= t_valid;
            role_reg   <= t_role;
            start_reg  <= t_start;
            dflt_reg   <= t_dflt;
            ecode_reg  <= err_next;
            done_reg   <= head_word.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign char_out      = char_reg;
    assign char_valid    = cvalid_reg;
    assign role          = role_reg;
    assign token_start   = start_reg;
    assign default_value = dflt_reg;
    assign error_code    = ecode_reg;
    assign done_res      = done_reg;

endmodule

`default_nettype wire
